/* rtl/core/texel_tint_alpha_blend_rgb565_unit_defines.svh */
// Assertion macros for the texel tint and blend unit.
`ifndef TEXEL_TINT_ALPHA_BLEND_RGB565_UNIT_DEFINES_SVH
`define TEXEL_TINT_ALPHA_BLEND_RGB565_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define TTAB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ttab assertion failed");

`define TTAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ttab assertion failed");

`else

`define TTAB_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define TTAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/ttab_pkg.sv */
// Shared types, constants and arithmetic helpers for the texel tint and blend unit.
`default_nettype none
package ttab_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned ALPHA_W = 6;
    localparam int unsigned COV_W   = 6;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned FIELD_W = 32;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [FIELD_W-1:0] FIELD_MASK = 32'h07E0_F81F;
    localparam logic [16:0]        ROUND_ADD  = 17'd127;

    localparam logic [CHAN_W-1:0]  TINT_RESET  = 8'd255;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 6'd32;

    localparam int unsigned COV_FULL_BIT = 5;

    typedef enum logic [1:0] {
        REG_TINT_RED   = 2'd0,
        REG_TINT_GREEN = 2'd1,
        REG_TINT_BLUE  = 2'd2,
        REG_TINT_ALPHA = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [COV_W-1:0]  cov;
        logic [PIX_W-1:0]  dest;
    } t_tint_word;

    // rounded divide by 255 of a product no larger than 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] prod);
        logic [16:0] y;
        logic [16:0] s;
        y = {1'b0, prod} + ROUND_ADD;
        s = y + {8'd0, y[16:8]} + 17'd1;
        return s[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                 input logic [CHAN_W-1:0] g,
                                                 input logic [CHAN_W-1:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [FIELD_W-1:0] spread565(input logic [PIX_W-1:0] p);
        return ({16'd0, p} | {p, 16'd0}) & FIELD_MASK;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/texel_tint_alpha_blend_rgb565_unit.sv */
// Top level of the texel tint and RGB565 alpha blend unit.
// Path: an accepted word passes the input, tint-product and result registers before the o_valid strobe.
// Throughput: one word per cycle; busy stays low, the three-register pipeline
// (input, tint products, result) takes a new word every cycle.
// Reset: synchronous active low; clears pipeline valids and sets tint registers
// to white, fully opaque. The result receiver cannot stall.
`default_nettype none
`include "texel_tint_alpha_blend_rgb565_unit_defines.svh"
module texel_tint_alpha_blend_rgb565_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ttab_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ttab_pkg::DATA_W-1:0]    pwdata,
    output logic      [ttab_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_red,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_green,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_blue,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_alpha,
    input  wire logic [ttab_pkg::PIX_W-1:0]     i_dest_pixel,
    output logic                                o_valid,
    output logic      [ttab_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                                o_write_enable
);
    import ttab_pkg::*;

    logic [CHAN_W-1:0]  tint_red;
    logic [CHAN_W-1:0]  tint_green;
    logic [CHAN_W-1:0]  tint_blue;
    logic [ALPHA_W-1:0] tint_alpha;
    logic               accept;
    t_tint_word         tint_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ttab_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_tint_red   (tint_red),
        .o_tint_green (tint_green),
        .o_tint_blue  (tint_blue),
        .o_tint_alpha (tint_alpha)
    );

    ttab_tint u_tint (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_texel_red   (i_texel_red),
        .i_texel_green (i_texel_green),
        .i_texel_blue  (i_texel_blue),
        .i_texel_alpha (i_texel_alpha),
        .i_dest_pixel  (i_dest_pixel),
        .i_tint_red    (tint_red),
        .i_tint_green  (tint_green),
        .i_tint_blue   (tint_blue),
        .i_tint_alpha  (tint_alpha),
        .o_word        (tint_word)
    );

    ttab_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (tint_word),
        .o_valid        (o_valid),
        .o_pixel_out    (o_pixel_out),
        .o_write_enable (o_write_enable)
    );

    `TTAB_ASSERT_SAME(a_strobe_follows_accept, i_clk, i_rst_n, 1'b1, o_valid == ($past(start && !busy && i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1)))
    `TTAB_ASSERT_SAME(a_skip_keeps_dest, i_clk, i_rst_n, o_valid && !o_write_enable, o_pixel_out == $past(i_dest_pixel, 3))
    `TTAB_ASSERT_SAME(a_clear_texel_no_write, i_clk, i_rst_n, o_valid && $past(i_texel_alpha, 3) == '0, !o_write_enable)

endmodule
`default_nettype wire

/* rtl/core/ttab_cfg.sv */
// APB register bank holding the tint color and tint alpha.
`default_nettype none
module ttab_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ttab_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ttab_pkg::DATA_W-1:0]    pwdata,
    output logic      [ttab_pkg::DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic      [ttab_pkg::CHAN_W-1:0]    o_tint_red,
    output logic      [ttab_pkg::CHAN_W-1:0]    o_tint_green,
    output logic      [ttab_pkg::CHAN_W-1:0]    o_tint_blue,
    output logic      [ttab_pkg::ALPHA_W-1:0]   o_tint_alpha
);
    import ttab_pkg::*;

    logic [CHAN_W-1:0]  r_tint_red;
    logic [CHAN_W-1:0]  r_tint_green;
    logic [CHAN_W-1:0]  r_tint_blue;
    logic [ALPHA_W-1:0] r_tint_alpha;
    t_reg_idx           reg_idx;
    logic               wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red   <= TINT_RESET;
            r_tint_green <= TINT_RESET;
            r_tint_blue  <= TINT_RESET;
            r_tint_alpha <= ALPHA_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TINT_RED:   r_tint_red   <= pwdata[CHAN_W-1:0];
                REG_TINT_GREEN: r_tint_green <= pwdata[CHAN_W-1:0];
                REG_TINT_BLUE:  r_tint_blue  <= pwdata[CHAN_W-1:0];
                REG_TINT_ALPHA: r_tint_alpha <= pwdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TINT_RED:   prdata = {{(DATA_W-CHAN_W){1'b0}}, r_tint_red};
            REG_TINT_GREEN: prdata = {{(DATA_W-CHAN_W){1'b0}}, r_tint_green};
            REG_TINT_BLUE:  prdata = {{(DATA_W-CHAN_W){1'b0}}, r_tint_blue};
            REG_TINT_ALPHA: prdata = {{(DATA_W-ALPHA_W){1'b0}}, r_tint_alpha};
            default:        prdata = '0;
        endcase
    end

    assign o_tint_red   = r_tint_red;
    assign o_tint_green = r_tint_green;
    assign o_tint_blue  = r_tint_blue;
    assign o_tint_alpha = r_tint_alpha;

endmodule
`default_nettype wire

/* rtl/core/ttab_tint.sv */
// Input register and tint stage: per-channel tint products and coverage.
`default_nettype none
module ttab_tint (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_red,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_green,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_blue,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_texel_alpha,
    input  wire logic [ttab_pkg::PIX_W-1:0]     i_dest_pixel,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_tint_red,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_tint_green,
    input  wire logic [ttab_pkg::CHAN_W-1:0]    i_tint_blue,
    input  wire logic [ttab_pkg::ALPHA_W-1:0]   i_tint_alpha,
    output ttab_pkg::t_tint_word                o_word
);
    import ttab_pkg::*;

    logic              r_in_valid;
    logic [CHAN_W-1:0] r_texel_red;
    logic [CHAN_W-1:0] r_texel_green;
    logic [CHAN_W-1:0] r_texel_blue;
    logic [CHAN_W-1:0] r_texel_alpha;
    logic [PIX_W-1:0]  r_dest;
    t_tint_word        r_word;
    t_tint_word        n_word;
    logic [15:0]       prod_red;
    logic [15:0]       prod_green;
    logic [15:0]       prod_blue;
    logic [15:0]       prod_alpha;
    logic [CHAN_W-1:0] cov_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_texel_red   <= i_texel_red;
            r_texel_green <= i_texel_green;
            r_texel_blue  <= i_texel_blue;
            r_texel_alpha <= i_texel_alpha;
            r_dest        <= i_dest_pixel;
        end
    end

    always_comb begin
        prod_red   = {8'd0, r_texel_red} * {8'd0, i_tint_red};
        prod_green = {8'd0, r_texel_green} * {8'd0, i_tint_green};
        prod_blue  = {8'd0, r_texel_blue} * {8'd0, i_tint_blue};
        prod_alpha = {8'd0, r_texel_alpha} * {10'd0, i_tint_alpha};
        cov_full   = div255(prod_alpha);

        n_word.valid = r_in_valid;
        n_word.red   = div255(prod_red);
        n_word.green = div255(prod_green);
        n_word.blue  = div255(prod_blue);
        n_word.cov   = cov_full[COV_W-1:0];
        n_word.dest  = r_dest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

/* rtl/core/ttab_blend.sv */
// Pack, blend against the framebuffer pixel, and register the result word.
`default_nettype none
module ttab_blend (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  ttab_pkg::t_tint_word                i_word,
    output logic                                o_valid,
    output logic      [ttab_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                                o_write_enable
);
    import ttab_pkg::*;

    logic                r_valid;
    logic                r_write_enable;
    logic [PIX_W-1:0]    r_pixel_out;
    logic                n_write_enable;
    logic [PIX_W-1:0]    n_pixel_out;
    logic [PIX_W-1:0]    src;
    logic [FIELD_W-1:0]  s_fld;
    logic [FIELD_W-1:0]  d_fld;
    logic [FIELD_W-1:0]  diff;
    logic [FIELD_W-1:0]  prod;
    logic [FIELD_W-1:0]  mix;
    logic [PIX_W-1:0]    blended;

    always_comb begin
        src     = pack565(i_word.red, i_word.green, i_word.blue);
        s_fld   = spread565(src);
        d_fld   = spread565(i_word.dest);
        diff    = s_fld - d_fld;
        prod    = diff * {{(FIELD_W-COV_W){1'b0}}, i_word.cov};
        mix     = ((prod >> 5) + d_fld) & FIELD_MASK;
        blended = mix[PIX_W-1:0] | mix[FIELD_W-1:PIX_W];

        if (i_word.cov == '0) begin
            n_write_enable = 1'b0;
            n_pixel_out    = i_word.dest;
        end else if (i_word.cov[COV_FULL_BIT]) begin
            n_write_enable = 1'b1;
            n_pixel_out    = src;
        end else begin
            n_write_enable = 1'b1;
            n_pixel_out    = blended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_write_enable <= 1'b0;
        end else begin
            r_valid        <= i_word.valid;
            r_write_enable <= i_word.valid && n_write_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel_out <= n_pixel_out;
    end

    assign o_valid        = r_valid;
    assign o_write_enable = r_write_enable;
    assign o_pixel_out    = r_pixel_out;

endmodule
`default_nettype wire
